### design/bdq_pkg.sv
// Shared types and codes for the bounded double-ended queue.
package bdq_pkg;

  // Width of the capacity register and of the reported count
  localparam int CAP_W = 5;
  localparam int DATA_W = 32;

  // Operation codes carried in func
  localparam logic [2:0] FUNC_PUSH_FRONT = 3'd0;
  localparam logic [2:0] FUNC_PUSH_BACK  = 3'd1;
  localparam logic [2:0] FUNC_POP_FRONT  = 3'd2;
  localparam logic [2:0] FUNC_POP_BACK   = 3'd3;
  localparam logic [2:0] FUNC_QUERY      = 3'd4;

  typedef logic signed [DATA_W-1:0] data_t;

  // Value shown for front and rear when the queue holds nothing
  localparam data_t EMPTY_READ = -32'sd1;

  typedef struct packed {
    logic [2:0] func;
    data_t      push_value;
  } req_t;

  typedef struct packed {
    logic             ok;
    data_t            front_value;
    data_t            rear_value;
    logic             is_empty;
    logic             is_full;
    logic [CAP_W-1:0] entry_count;
  } rsp_t;

  typedef logic [CAP_W-1:0] cfg_t;

  // What every cell does in a cycle
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_SHR,
    CELL_SHL,
    CELL_APPEND,
    CELL_TRUNC
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    data_t    push_val;
  } cell_ctrl_t;

endpackage

### design/bdq_chan_if.sv
// Valid/ready channel carrying one word of type T.
interface bdq_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### design/bounded_double_ended_queue.sv
// Bounded double-ended queue: top level with the cell row, count and result register.
//
// The queue is a row of DEPTH cells with the front in cell 0; pushes and pops at
// the front shift the whole row by one place, pushes and pops at the back touch
// only the cell at the end of the occupied run. One operation is taken per clock:
// req_i is ready whenever the result register is empty or its word is being taken,
// and the result appears on rsp_o the cycle after acceptance. A result word reports
// the state after its operation. The capacity register (cfg_i) is always ready and
// may be written whenever the block is idle; values above DEPTH act as DEPTH.
// Cell contents need no clearing after reset, so the block is ready straight away.
module bounded_double_ended_queue
  import bdq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  bdq_chan_if.sink   req_i,
  bdq_chan_if.sink   cfg_i,
  bdq_chan_if.source rsp_o
);

  localparam int CntW = $clog2(DEPTH + 1);
  localparam int CmpW = (CntW > CAP_W) ? CntW : CAP_W;
  localparam logic [CmpW-1:0] DepthC = CmpW'(DEPTH);

  logic [CntW-1:0] count_q, count_d;
  cfg_t            cap_q;
  logic            rsp_valid_q;
  logic            ok_q, ok_d;
  logic            accept;

  cell_ctrl_t        ctrl;
  logic [DEPTH-1:0]  occ;
  logic [DEPTH-1:0]  last;
  data_t             val [DEPTH];

  logic [CmpW-1:0] cnt_ext, cap_ext, eff_cap;
  logic            full, empty;
  data_t           rear_or;

  // Capacity register
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_W'(16);
    end else if (cfg_i.valid) begin
      cap_q <= cfg_i.payload;
    end
  end

  // Fullness against the clipped capacity
  assign cnt_ext = CmpW'(count_q);
  assign cap_ext = CmpW'(cap_q);
  assign eff_cap = (cap_ext > DepthC) ? DepthC : cap_ext;
  assign full    = cnt_ext >= eff_cap;
  assign empty   = (count_q == '0);

  assign req_i.ready = ~rsp_valid_q | rsp_o.ready;
  assign accept      = req_i.valid & req_i.ready;

  // Decode the operation into a row command and the count update
  always_comb begin
    ctrl.op       = CELL_HOLD;
    ctrl.push_val = req_i.payload.push_value;
    ok_d          = 1'b0;
    count_d       = count_q;
    case (req_i.payload.func)
      FUNC_PUSH_FRONT: begin
        if (!full) begin
          ctrl.op = CELL_SHR;
          ok_d    = 1'b1;
          count_d = count_q + 1'b1;
        end
      end
      FUNC_PUSH_BACK: begin
        if (!full) begin
          ctrl.op = CELL_APPEND;
          ok_d    = 1'b1;
          count_d = count_q + 1'b1;
        end
      end
      FUNC_POP_FRONT: begin
        if (!empty) begin
          ctrl.op = CELL_SHL;
          ok_d    = 1'b1;
          count_d = count_q - 1'b1;
        end
      end
      FUNC_POP_BACK: begin
        if (!empty) begin
          ctrl.op = CELL_TRUNC;
          ok_d    = 1'b1;
          count_d = count_q - 1'b1;
        end
      end
      FUNC_QUERY: begin
        ok_d = 1'b1;
      end
      default: begin
        ok_d = 1'b0;
      end
    endcase
    if (!accept) begin
      ctrl.op = CELL_HOLD;
    end
  end

  // Row of cells, cell 0 is the front
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic  l_occ, r_occ;
    data_t l_val, r_val;
    if (i == 0) begin : g_first
      assign l_occ = 1'b1;
      assign l_val = req_i.payload.push_value;
    end else begin : g_mid_l
      assign l_occ = occ[i-1];
      assign l_val = val[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign r_occ = 1'b0;
      assign r_val = '0;
    end else begin : g_mid_r
      assign r_occ = occ[i+1];
      assign r_val = val[i+1];
    end
    bdq_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .left_occ_i  (l_occ),
      .left_val_i  (l_val),
      .right_occ_i (r_occ),
      .right_val_i (r_val),
      .occ_o       (occ[i]),
      .last_o      (last[i]),
      .val_o       (val[i])
    );
  end

  // Count and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
      ok_q        <= 1'b0;
    end else begin
      if (accept) begin
        count_q <= count_d;
        ok_q    <= ok_d;
      end
      if (req_i.ready) begin
        rsp_valid_q <= req_i.valid;
      end
    end
  end

  // Rear word: one-hot pick of the last occupied cell
  always_comb begin
    rear_or = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rear_or = rear_or | (last[i] ? val[i] : data_t'(0));
    end
  end

  // State does not move while a result waits, so the word is read from it
  assign rsp_o.valid               = rsp_valid_q;
  assign rsp_o.payload.ok          = ok_q;
  assign rsp_o.payload.front_value = empty ? EMPTY_READ : val[0];
  assign rsp_o.payload.rear_value  = empty ? EMPTY_READ : rear_or;
  assign rsp_o.payload.is_empty    = empty;
  assign rsp_o.payload.is_full     = full;
  assign rsp_o.payload.entry_count = cnt_ext[CAP_W-1:0];

  // Count tracks the occupied cells
  a_count_occ : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == CntW'($countones(occ)))
    else $error("count differs from occupied cells");

  // Occupied cells form one run from the front
  a_occ_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((occ + 1'b1) & occ) == '0)
    else $error("gap in occupied cells");

  // A successful push grows the count by one
  a_push_grow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && ok_d && (ctrl.op == CELL_SHR || ctrl.op == CELL_APPEND))
      |=> count_q == CntW'($past(count_q) + 1'b1))
    else $error("push did not grow count");

  // A waiting result freezes the queue
  a_stall_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && !rsp_o.ready) |=> ($stable(count_q) && $stable(occ)))
    else $error("queue moved under a stalled result");

  // Count never passes the row length
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_ext <= DepthC)
    else $error("count beyond depth");

endmodule

### design/bdq_cell.sv
// One storage cell of the queue row: a value, its occupancy and its neighbour moves.
module bdq_cell
  import bdq_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  logic       left_occ_i,
  input  data_t      left_val_i,
  input  logic       right_occ_i,
  input  data_t      right_val_i,
  output logic       occ_o,
  output logic       last_o,
  output data_t      val_o
);

  logic  occ_q, occ_d;
  data_t val_q, val_d;
  logic  val_en;

  // Next occupancy and value from the row-wide operation
  always_comb begin
    occ_d  = occ_q;
    val_d  = left_val_i;
    val_en = 1'b0;
    case (ctrl_i.op)
      CELL_SHR: begin
        occ_d  = left_occ_i;
        val_d  = left_val_i;
        val_en = 1'b1;
      end
      CELL_SHL: begin
        occ_d  = right_occ_i;
        val_d  = right_val_i;
        val_en = 1'b1;
      end
      CELL_APPEND: begin
        // first free cell after the occupied run takes the word
        if (!occ_q && left_occ_i) begin
          occ_d  = 1'b1;
          val_d  = ctrl_i.push_val;
          val_en = 1'b1;
        end
      end
      CELL_TRUNC: begin
        // last occupied cell lets go
        if (occ_q && !right_occ_i) begin
          occ_d = 1'b0;
        end
      end
      default: begin
        occ_d = occ_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (val_en) begin
      val_q <= val_d;
    end
  end

  assign occ_o  = occ_q;
  assign last_o = occ_q & ~right_occ_i;
  assign val_o  = val_q;

endmodule

### test/bounded_double_ended_queue_test.sv
// Testbench for the bounded double-ended queue: directed, pressure and random tests.
`timescale 1ns / 100ps

module bounded_double_ended_queue_test;
  import bdq_pkg::*;

  localparam int DEPTH = 16;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES = 80;
  localparam int SEGMENT_WORDS = 160;

  // Codes outside the defined operations
  localparam logic [2:0] FUNC_RSVD_LO = 3'd5;
  localparam logic [2:0] FUNC_RSVD_HI = 3'd7;

  logic clk = 1'b0;
  logic rst_n;

  bdq_chan_if #(.T(req_t)) req_if ();
  bdq_chan_if #(.T(cfg_t)) cfg_if ();
  bdq_chan_if #(.T(rsp_t)) rsp_if ();

  bounded_double_ended_queue #(
    .DEPTH(DEPTH)
  ) DUT (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_if),
    .cfg_i (cfg_if),
    .rsp_o (rsp_if)
  );

  // Clock, 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mirror of the queue contents and the capacity register
  data_t ring [DEPTH];
  int    head_pos;
  int    held;
  int    capacity_reg;

  rsp_t  pending_rsp [$];
  int    fail_count;
  int    send_idle_pct;
  int    stall_pct;
  int    hold_left;

  // Apply one operation to the mirror and return the word it should produce
  function automatic rsp_t deque_apply(logic [2:0] func, data_t value);
    rsp_t rsp;
    int   lim;
    logic ok;
    lim = (capacity_reg > DEPTH) ? DEPTH : capacity_reg;
    ok = 1'b0;
    case (func)
      FUNC_PUSH_FRONT: begin
        if (held < lim) begin
          head_pos = (head_pos + DEPTH - 1) % DEPTH;
          ring[head_pos] = value;
          held++;
          ok = 1'b1;
        end
      end
      FUNC_PUSH_BACK: begin
        if (held < lim) begin
          ring[(head_pos + held) % DEPTH] = value;
          held++;
          ok = 1'b1;
        end
      end
      FUNC_POP_FRONT: begin
        if (held != 0) begin
          head_pos = (head_pos + 1) % DEPTH;
          held--;
          ok = 1'b1;
        end
      end
      FUNC_POP_BACK: begin
        if (held != 0) begin
          held--;
          ok = 1'b1;
        end
      end
      FUNC_QUERY: ok = 1'b1;
      default: ok = 1'b0;
    endcase
    rsp.ok          = ok;
    rsp.front_value = (held != 0) ? ring[head_pos] : EMPTY_READ;
    rsp.rear_value  = (held != 0) ? ring[(head_pos + held - 1) % DEPTH] : EMPTY_READ;
    rsp.is_empty    = (held == 0);
    rsp.is_full     = (held >= lim);
    rsp.entry_count = CAP_W'(held);
    return rsp;
  endfunction

  // Offer one request word, optionally after an idle gap, and log its expected result
  task automatic send_op(input logic [2:0] func, input data_t value);
    if ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    req_if.valid   <= 1'b1;
    req_if.payload <= '{func: func, push_value: value};
    do @(posedge clk); while (!req_if.ready);
    pending_rsp.push_back(deque_apply(func, value));
  endtask

  // Stop offering and wait until every expected word has been taken
  task automatic drain;
    req_if.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
  endtask

  // Write the capacity register with the block idle
  task automatic set_capacity(input int value);
    drain();
    cfg_if.valid   <= 1'b1;
    cfg_if.payload <= cfg_t'(value);
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid   <= 1'b0;
    capacity_reg = value;
  endtask

  function automatic data_t pick_value();
    case ($urandom_range(9))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return -32'sd1;
      3: return 32'sd0;
      default: return data_t'($urandom);
    endcase
  endfunction

  task automatic test_directed;
    send_idle_pct = 0;
    stall_pct = 0;
    // empty queue: query and pops that must fail
    send_op(FUNC_QUERY, 32'sd0);
    send_op(FUNC_POP_FRONT, 32'sd0);
    send_op(FUNC_POP_BACK, 32'sd0);
    // extremes of the value at either end
    send_op(FUNC_PUSH_FRONT, 32'sh7FFF_FFFF);
    send_op(FUNC_PUSH_BACK, 32'sh8000_0000);
    send_op(FUNC_POP_FRONT, 32'sd0);
    send_op(FUNC_POP_BACK, 32'sd0);
    // reserved codes do nothing
    for (int f = FUNC_RSVD_LO; f <= FUNC_RSVD_HI; f++) send_op(3'(f), -32'sd1);
    // zero capacity: empty and full at once
    set_capacity(0);
    send_op(FUNC_PUSH_FRONT, 32'sd11);
    send_op(FUNC_PUSH_BACK, 32'sd12);
    send_op(FUNC_QUERY, 32'sd0);
    // capacity of one
    set_capacity(1);
    send_op(FUNC_PUSH_BACK, 32'sd55);
    send_op(FUNC_PUSH_FRONT, 32'sd66);
    send_op(FUNC_POP_FRONT, 32'sd0);
    // capacity lowered below the count keeps the entries
    set_capacity(16);
    for (int i = 0; i < 3; i++) send_op(FUNC_PUSH_BACK, data_t'(100 + i));
    set_capacity(2);
    send_op(FUNC_PUSH_BACK, 32'sd200);
    send_op(FUNC_POP_BACK, 32'sd0);
    send_op(FUNC_POP_BACK, 32'sd0);
    send_op(FUNC_PUSH_FRONT, 32'sd300);
  endtask

  // Output held off for a long stretch while the sender keeps offering
  task automatic test_backpressure;
    set_capacity(16);
    send_idle_pct = 0;
    stall_pct = 0;
    hold_left = HOLD_CYCLES;
    for (int i = 0; i < 24; i++) begin
      send_op((i % 3 == 2) ? FUNC_POP_FRONT : FUNC_PUSH_BACK, pick_value());
    end
  endtask

  task automatic test_random;
    int caps [8] = '{31, 16, 1, 7, 0, 16, 3, 20};
    int idle [4] = '{0, 58, 0, 18};
    int stall [4] = '{0, 0, 58, 18};
    int bias;
    int r;
    logic [2:0] func;
    for (int seg = 0; seg < 8; seg++) begin
      set_capacity(caps[seg]);
      send_idle_pct = idle[seg % 4];
      stall_pct = stall[seg % 4];
      bias = 50;
      for (int i = 0; i < SEGMENT_WORDS; i++) begin
        // swing between filling and emptying runs
        if (i % 32 == 0) bias = $urandom_range(85, 15);
        r = $urandom_range(99);
        if (r < bias) func = $urandom_range(1) ? FUNC_PUSH_BACK : FUNC_PUSH_FRONT;
        else if (r < 95) func = $urandom_range(1) ? FUNC_POP_BACK : FUNC_POP_FRONT;
        else if (r < 98) func = FUNC_QUERY;
        else func = 3'($urandom_range(FUNC_RSVD_HI, FUNC_RSVD_LO));
        send_op(func, pick_value());
      end
    end
  endtask

  // Main sequence
  initial begin
    rst_n          <= 1'b0;
    req_if.valid   <= 1'b0;
    req_if.payload <= '0;
    cfg_if.valid   <= 1'b0;
    cfg_if.payload <= '0;
    head_pos = 0;
    held = 0;
    capacity_reg = 16;
    fail_count = 0;
    send_idle_pct = 0;
    stall_pct = 0;
    hold_left = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_backpressure();
    test_random();

    drain();
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Result receiver: random stalls, plus a counted hold-off on request
  initial begin
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        rsp_if.ready <= 1'b0;
        hold_left--;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  // Check every result word against the oldest expectation
  always @(posedge clk) begin
    rsp_t want;
    rsp_t got;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      got = rsp_if.payload;
      if (pending_rsp.size() == 0) begin
        $error("result word with no expectation waiting");
        fail_count++;
      end else begin
        want = pending_rsp.pop_front();
        compare_field("ok", 32'(want.ok), 32'(got.ok));
        compare_field("front_value", want.front_value, got.front_value);
        compare_field("rear_value", want.rear_value, got.rear_value);
        compare_field("is_empty", 32'(want.is_empty), 32'(got.is_empty));
        compare_field("is_full", 32'(want.is_full), 32'(got.is_full));
        compare_field("entry_count", 32'(want.entry_count), 32'(got.entry_count));
      end
    end
  end

  // Watchdog: too long without any handshake ends the run
  always @(posedge clk) begin
    int quiet;
    if ((req_if.valid && req_if.ready) || (cfg_if.valid && cfg_if.ready) ||
        (rsp_if.valid && rsp_if.ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

endmodule

### bounded_double_ended_queue.f
design/bdq_pkg.sv
design/bdq_chan_if.sv
design/bdq_cell.sv
design/bounded_double_ended_queue.sv
test/bounded_double_ended_queue_test.sv
